/* rtl/sorted_priority_queue_top_assert.svh */
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// checked only while out of reset
`define SPQ_ASSERT_RUN(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("spq assertion failed");

// checked at every edge
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("spq assertion failed");

`endif

/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

    // default number of queue slots
    localparam int DEPTH_DEFAULT = 16;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_EXTRACT = 2'd1,
        FUNC_CLEAR   = 2'd2
    } spq_func_t;

    // input item
    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } spq_in_t;

    // result item
    typedef struct packed {
        logic               done_res;
        logic signed [31:0] out_value;
        logic [4:0]         count;
        logic               is_empty;
        logic               is_full;
    } spq_out_t;

    // one stored pair
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } spq_entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic ext;
    } spq_ctl_t;

endpackage

/* rtl/spq_cell.sv */
`timescale 1ns / 1ps

module spq_cell (
    input  logic                  aclk,
    input  spq_pkg::spq_ctl_t     ctl,
    input  spq_pkg::spq_entry_t   new_entry,
    input  spq_pkg::spq_entry_t   left_entry,
    input  spq_pkg::spq_entry_t   right_entry,
    input  logic                  left_stay,
    input  logic                  occ,
    output spq_pkg::spq_entry_t   entry,
    output logic                  stay
);

    spq_pkg::spq_entry_t entry_reg;
    spq_pkg::spq_entry_t entry_next;

    // an occupied entry stays put on insert when its priority is at least the new one
    assign stay = occ && !(entry_reg.prio < new_entry.prio);

    // pick keep, new item, left neighbor or right neighbor
    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins) begin
            if (!stay) begin
                entry_next = left_stay ? new_entry : left_entry;
            end
        end else if (ctl.ext) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* rtl/sorted_priority_queue_top.sv */
`timescale 1ns / 1ps

// channel | handshake          | payload
// --------+--------------------+---------------------------------------------
// input   | s_valid / s_ready  | s_item: func, item_value, item_priority
// result  | m_valid / m_ready  | m_item: done_res, out_value, count, is_empty,
//         |                    |         is_full
//
// one item per cycle while s_ready is high: every cell compares its own priority with the new one
// in parallel and shifts in the same cycle; the result is registered and ready in the cycle
// after the item is taken.
// s_ready is high while the result register is empty or being drained.
// reset empties the queue and the result register; slot contents are left.

`include "sorted_priority_queue_top_assert.svh"

module sorted_priority_queue_top #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  spq_pkg::spq_in_t   s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output spq_pkg::spq_out_t  m_item
);

    localparam int CntW = $clog2(DEPTH + 1);

    logic [CntW-1:0]     count_reg;
    logic [CntW-1:0]     count_next;
    logic                m_valid_reg;
    spq_pkg::spq_out_t   m_item_reg;
    spq_pkg::spq_out_t   m_item_next;

    logic                accept;
    logic                is_full_now;
    logic                is_empty_now;
    spq_pkg::spq_ctl_t   ctl;
    logic                done;
    spq_pkg::spq_entry_t new_entry;

    spq_pkg::spq_entry_t cell_entry [DEPTH];
    logic [DEPTH-1:0]    cell_stay;
    logic [DEPTH-1:0]    cell_occ;
    logic [CntW+4:0]     count_ext;

    assign s_ready      = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign is_full_now  = (count_reg == CntW'(DEPTH));
    assign is_empty_now = (count_reg == '0);

    assign new_entry.value = s_item.item_value;
    assign new_entry.prio  = s_item.item_priority;

    // decode the operation and the next count
    always_comb begin
        ctl        = '0;
        done       = 1'b0;
        count_next = count_reg;
        case (spq_pkg::spq_func_t'(s_item.func))
            spq_pkg::FUNC_INSERT: begin
                if (!is_full_now) begin
                    ctl.ins    = accept;
                    done       = 1'b1;
                    count_next = count_reg + CntW'(1);
                end
            end
            spq_pkg::FUNC_EXTRACT: begin
                if (!is_empty_now) begin
                    ctl.ext    = accept;
                    done       = 1'b1;
                    count_next = count_reg - CntW'(1);
                end
            end
            spq_pkg::FUNC_CLEAR: begin
                done       = 1'b1;
                count_next = '0;
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    // row of cells, slot 0 is the head
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign cell_occ[i] = (count_reg > CntW'(i));
        spq_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
            .right_entry ((i == DEPTH - 1) ? cell_entry[i]
                                           : cell_entry[(i == DEPTH - 1) ? i : i + 1]),
            .left_stay   ((i == 0) ? 1'b1 : cell_stay[(i == 0) ? 0 : i - 1]),
            .occ         (cell_occ[i]),
            .entry       (cell_entry[i]),
            .stay        (cell_stay[i])
        );
    end

    // result fields
    assign count_ext = {5'b0, count_next};
    always_comb begin
        m_item_next.done_res  = done;
        m_item_next.out_value = (spq_pkg::spq_func_t'(s_item.func) == spq_pkg::FUNC_EXTRACT
                                 && !is_empty_now) ? cell_entry[0].value : '0;
        m_item_next.count     = count_ext[4:0];
        m_item_next.is_empty  = (count_next == '0);
        m_item_next.is_full   = (count_next == CntW'(DEPTH));
    end

    // count and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // count never passes the queue size
    `SPQ_ASSERT_RUN(a_count_bound, aclk, aresetn, count_reg <= CntW'(DEPTH))
    // a taken clear leaves the queue empty
    `SPQ_ASSERT_RUN(a_clear_empties, aclk, aresetn,
        accept && s_item.func == spq_pkg::FUNC_CLEAR |=> count_reg == '0)
    // a successful insert grows the count by one
    `SPQ_ASSERT_RUN(a_insert_grows, aclk, aresetn,
        ctl.ins |=> count_reg == $past(count_reg) + CntW'(1))
    // an extract from an empty queue is flagged and returns zero
    `SPQ_ASSERT_RUN(a_empty_extract, aclk, aresetn,
        accept && s_item.func == spq_pkg::FUNC_EXTRACT && is_empty_now
        |=> m_valid && !m_item.done_res && m_item.out_value == '0)
    // insert and extract never both drive the cells
    `SPQ_ASSERT_ALWAYS(a_ctl_excl, aclk, !(ctl.ins && ctl.ext))

endmodule

/* dv/sorted_priority_queue_top_tb.sv */
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;

    localparam int         QUEUE_DEPTH   = spq_pkg::DEPTH_DEFAULT;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam int         MAX_WAIT      = 18;
    localparam int         STALL_LIMIT   = 1000;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         CHUNK_ITEMS   = 40;
    localparam int         CHUNKS        = 8;

    localparam logic signed [31:0] PRIO_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    spq_pkg::spq_in_t  s_item;
    logic              m_valid;
    logic              m_ready;
    spq_pkg::spq_out_t m_item;

    sorted_priority_queue_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // shadow copy of the sorted queue
    logic signed [31:0] shadow_value [QUEUE_DEPTH];
    logic signed [31:0] shadow_prio  [QUEUE_DEPTH];
    int                 shadow_count;

    spq_pkg::spq_out_t pending_results [$];

    int mismatches;
    int items_sent;
    int results_seen;
    int full_drops;
    int empty_extracts;
    int idle_cycles;
    int ready_hold;
    bit pace_sender;
    bit pace_receiver;

    // clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = ~aclk;
    end

    // apply one operation to the shadow queue and work out its result item
    function automatic spq_pkg::spq_out_t apply_queue_op(input spq_pkg::spq_in_t op_item);
        spq_pkg::spq_out_t res;
        int                pos;
        int                i;
        res = '0;
        case (op_item.func)
            spq_pkg::FUNC_INSERT: begin
                if (shadow_count < QUEUE_DEPTH) begin
                    // new entry goes behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < shadow_count &&
                           shadow_prio[pos] >= $signed(op_item.item_priority)) begin
                        pos++;
                    end
                    for (i = shadow_count; i > pos; i--) begin
                        shadow_value[i] = shadow_value[i - 1];
                        shadow_prio[i]  = shadow_prio[i - 1];
                    end
                    shadow_value[pos] = op_item.item_value;
                    shadow_prio[pos]  = op_item.item_priority;
                    shadow_count++;
                    res.done_res = 1'b1;
                end else begin
                    full_drops++;
                end
            end
            spq_pkg::FUNC_EXTRACT: begin
                if (shadow_count > 0) begin
                    res.out_value = shadow_value[0];
                    for (i = 0; i + 1 < shadow_count; i++) begin
                        shadow_value[i] = shadow_value[i + 1];
                        shadow_prio[i]  = shadow_prio[i + 1];
                    end
                    shadow_count--;
                    res.done_res = 1'b1;
                end else begin
                    empty_extracts++;
                end
            end
            spq_pkg::FUNC_CLEAR: begin
                shadow_count = 0;
                res.done_res = 1'b1;
            end
            default: begin
                // unused code leaves the queue alone
            end
        endcase
        res.count    = shadow_count[4:0];
        res.is_empty = (shadow_count == 0);
        res.is_full  = (shadow_count == QUEUE_DEPTH);
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result(input spq_pkg::spq_out_t got);
        spq_pkg::spq_out_t want;
        if (pending_results.size() == 0) begin
            $error("result item arrived with nothing expected");
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
        compare_field("out_value", want.out_value, got.out_value);
        compare_field("count", 32'(want.count), 32'(got.count));
        compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
        compare_field("is_full", 32'(want.is_full), 32'(got.is_full));
    endfunction

    // monitor both channels at the rising edge, plus the stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_results.push_back(apply_queue_op(s_item));
            end
            if (m_valid && m_ready) begin
                check_result(m_item);
                results_seen++;
                ready_hold = pace_receiver ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // drive one item and hold it until accepted
    task automatic send_item(input logic [1:0] op, input logic signed [31:0] val,
                             input logic signed [31:0] prio);
        spq_pkg::spq_in_t op_item;
        int               gap;
        op_item.func          = op;
        op_item.item_value    = val;
        op_item.item_priority = prio;
        gap = pace_sender ? $urandom_range(0, MAX_WAIT) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_item  <= op_item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // stop sending and let every expected result come back
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // half the time a narrow band so ties are common, otherwise extremes or any value
    function automatic logic signed [31:0] random_priority();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0:       return PRIO_MAX;
            1:       return PRIO_MIN;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 6) - 3;
        endcase
    endfunction

    task automatic send_random_op(input int insert_pct);
        int         roll;
        logic [1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            op = spq_pkg::FUNC_CLEAR;
        end else if (roll < 6) begin
            op = FUNC_UNUSED;
        end else if (roll < 6 + insert_pct * 94 / 100) begin
            op = spq_pkg::FUNC_INSERT;
        end else begin
            op = spq_pkg::FUNC_EXTRACT;
        end
        send_item(op, $urandom, random_priority());
    endtask

    // extremes, ties, unused code, clear, empty extract
    task automatic test_directed_cases();
        pace_sender   = 1'b1;
        pace_receiver = 1'b1;
        send_item(spq_pkg::FUNC_EXTRACT, 32'sd0, 32'sd0);
        send_item(FUNC_UNUSED, 32'shffff_ffff, 32'shffff_ffff);
        send_item(spq_pkg::FUNC_INSERT, 32'sh7fff_ffff, PRIO_MIN);
        send_item(spq_pkg::FUNC_INSERT, 32'sh8000_0000, PRIO_MAX);
        send_item(spq_pkg::FUNC_INSERT, 32'sd1, 32'sd0);
        send_item(spq_pkg::FUNC_INSERT, 32'sd2, 32'sd0);
        send_item(spq_pkg::FUNC_INSERT, -32'sd1, -32'sd1);
        send_item(spq_pkg::FUNC_INSERT, 32'sd3, 32'sd0);
        send_item(spq_pkg::FUNC_INSERT, 32'sd4, PRIO_MAX);
        repeat (4) send_item(spq_pkg::FUNC_EXTRACT, 32'shffff_ffff, 32'shffff_ffff);
        send_item(FUNC_UNUSED, 32'shffff_ffff, 32'sh0);
        send_item(spq_pkg::FUNC_CLEAR, 32'sh5555_5555, 32'shaaaa_aaaa);
        send_item(spq_pkg::FUNC_EXTRACT, 32'sd0, 32'sd0);
        send_item(spq_pkg::FUNC_CLEAR, 32'sd0, 32'sd0);
        send_item(spq_pkg::FUNC_INSERT, 32'sd0, 32'sd0);
        send_item(spq_pkg::FUNC_EXTRACT, 32'sd0, 32'sd0);
        wait_for_results();
    endtask

    // fill to the limit back to back, overflow, drain past empty, then refill and clear
    task automatic test_full_queue();
        pace_sender   = 1'b0;
        pace_receiver = 1'b0;
        send_item(spq_pkg::FUNC_CLEAR, 32'sd0, 32'sd0);
        repeat (QUEUE_DEPTH) send_item(spq_pkg::FUNC_INSERT, $urandom, random_priority());
        repeat (2) send_item(spq_pkg::FUNC_INSERT, $urandom, random_priority());
        send_item(FUNC_UNUSED, $urandom, $urandom);
        repeat (QUEUE_DEPTH + 1) send_item(spq_pkg::FUNC_EXTRACT, $urandom, $urandom);
        repeat (QUEUE_DEPTH) send_item(spq_pkg::FUNC_INSERT, $urandom, random_priority());
        send_item(spq_pkg::FUNC_CLEAR, $urandom, $urandom);
        wait_for_results();
    endtask

    // random mix in chunks with rotating fill bias and varied pacing
    task automatic test_random_traffic();
        int chunk;
        int insert_pct;
        for (chunk = 0; chunk < CHUNKS; chunk++) begin
            if (chunk < 4) begin
                pace_sender   = chunk[0];
                pace_receiver = chunk[1];
            end else begin
                pace_sender   = $urandom_range(0, 1);
                pace_receiver = $urandom_range(0, 1);
            end
            case (chunk % 3)
                0:       insert_pct = 75;
                1:       insert_pct = 50;
                default: insert_pct = 25;
            endcase
            repeat (CHUNK_ITEMS) send_random_op(insert_pct);
            // sender holds off until the queue has answered everything
            if (chunk == CHUNKS / 2) begin
                wait_for_results();
            end
        end
        wait_for_results();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_item         = '0;
        m_ready        = 1'b0;
        shadow_count   = 0;
        mismatches     = 0;
        items_sent     = 0;
        results_seen   = 0;
        full_drops     = 0;
        empty_extracts = 0;
        idle_cycles    = 0;
        ready_hold     = 0;
        pace_sender    = 1'b0;
        pace_receiver  = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_full_queue();
        test_random_traffic();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected result items never arrived", pending_results.size());
            mismatches++;
        end

        $display("covered %0d items and %0d results, %0d inserts into a full queue,",
                 items_sent, results_seen, full_drops);
        $display("%0d extracts from an empty queue, clears, unused codes, paced and back to back",
                 empty_extracts);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
dv/sorted_priority_queue_top_tb.sv
